@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the motif score core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/spms_pkg.sv @@
// Types, constants and helpers of the sliding motif score core.
`default_nettype none

package spms_pkg;

	// Chain geometry and word widths
	localparam int MAX_MOTIF_LEN = 32;
	localparam int COL_W   = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
	localparam int LEN_W   = 7;
	localparam int WGT_W   = 16;
	localparam int SUM_W   = WGT_W + $clog2(MAX_MOTIF_LEN);
	localparam int REC_W   = 32;
	localparam int PROD_W  = SUM_W + REC_W + 1;
	localparam int NORM_W  = 24;
	localparam int RND_SHIFT = 9;
	localparam int QUO_W   = PROD_W - RND_SHIFT;

	localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(256);
	localparam logic signed [QUO_W-1:0]  NORM_MAX = QUO_W'(8388607);
	localparam logic signed [QUO_W-1:0]  NORM_MIN = -QUO_W'(8388608);

	// Register indexes
	localparam logic REG_MOTIF_LENGTH = 1'b0;
	localparam logic REG_SCORE_RECIP  = 1'b1;

	// Reset values of the registers
	localparam logic [5:0]       MOTIF_LENGTH_RST = 6'd1;
	localparam logic [REC_W-1:0] SCORE_RECIP_RST  = REC_W'(65536);

	// Input word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_BASE = 1'b1;

	// Result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	// Matrix rows
	localparam logic [1:0] ROW_A = 2'd0;
	localparam logic [1:0] ROW_C = 2'd1;
	localparam logic [1:0] ROW_G = 2'd2;
	localparam logic [1:0] ROW_T = 2'd3;

	// Base characters
	localparam logic [7:0] CHAR_A_UP = 8'h41;
	localparam logic [7:0] CHAR_A_LO = 8'h61;
	localparam logic [7:0] CHAR_C_UP = 8'h43;
	localparam logic [7:0] CHAR_C_LO = 8'h63;
	localparam logic [7:0] CHAR_G_UP = 8'h47;
	localparam logic [7:0] CHAR_G_LO = 8'h67;
	localparam logic [7:0] CHAR_T_UP = 8'h54;
	localparam logic [7:0] CHAR_T_LO = 8'h74;

	// Weight write broadcast to the cells
	typedef struct packed {
		logic              en;
		logic [1:0]        row;
		logic [WGT_W-1:0]  value;
	} wt_wr_t;

	// Base step broadcast to the cells
	typedef struct packed {
		logic       shift;
		logic       hit;
		logic [1:0] row;
	} cell_ctl_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] row;
	} base_dec_t;

	// Map a character to its matrix row; other bytes miss
	function automatic base_dec_t decode_base(input logic [7:0] c);
		base_dec_t d;
		d.hit = 1'b1;
		d.row = ROW_A;
		unique case (c)
			CHAR_A_UP, CHAR_A_LO: d.row = ROW_A;
			CHAR_C_UP, CHAR_C_LO: d.row = ROW_C;
			CHAR_G_UP, CHAR_G_LO: d.row = ROW_G;
			CHAR_T_UP, CHAR_T_LO: d.row = ROW_T;
			default:              d.hit = 1'b0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ hdl/spms_cell.sv @@
// One motif column: its four weights and the partial sum of one window.
`default_nettype none

module spms_cell import spms_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wt_wr_t                  wr,
	input  cell_ctl_t               ctl,
	input  logic                    take,
	input  logic signed [SUM_W-1:0] sum_in,
	output logic signed [SUM_W-1:0] sum_out
);

	logic [WGT_W-1:0]        w_q [4];
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] w_ext;

	// Store this column's weight for the addressed row
	always_ff @(posedge clk) begin
		if (wr.en) begin
			w_q[wr.row] <= wr.value;
		end
	end

	// Advance the window sum from the left neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.shift && take) begin
			sum_q <= sum_in;
		end
	end

	// Add this column's weight for the current base
	always_comb begin
		w_ext = ctl.hit ? SUM_W'($signed(w_q[ctl.row])) : '0;
		sum_out = sum_q + w_ext;
	end

endmodule

`default_nettype wire

@@ hdl/sliding_pwm_motif_score_core.sv @@
// Top level of the sliding position weight matrix motif score core.
// Input channel (in_valid/in_stall) carries one word per accept: kind 0 loads
// one weight (row, column, Q8.8 value), kind 1 presents one base character
// with seq_first/seq_final marks. A row of cells, one per motif column, holds
// the partial sum of every window in flight; each base moves all of them one
// column in the same cycle, so one word is taken per cycle unless stalled.
// Output channel (out_valid/out_stall) carries norm_score (Q8.15, saturated),
// status and window_last. Once motif_length bases of a sequence are in, every
// base gives one score; a final base of a too-short sequence gives one result
// with status 1. Loads give nothing.
// A result is registered after each step: window sum, multiply by
// score_reciprocal, round and saturate. Throughput is one word per cycle.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle.
// Reset clears the window sums, the base count and the pipeline, and sets
// motif_length to 1 and score_reciprocal to 1.0. Weights are undefined until
// loaded. Write the registers only while no result is pending.
`default_nettype none

`include "assert_macros.svh"

module sliding_pwm_motif_score_core import spms_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [REC_W-1:0]         cfg_data,
	// Input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic [1:0]               weight_row,
	input  logic [4:0]               weight_column,
	input  logic signed [WGT_W-1:0]  weight_value,
	input  logic [7:0]               base_char,
	input  logic                     seq_first,
	input  logic                     seq_final,
	// Output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [NORM_W-1:0] norm_score,
	output logic                     status,
	output logic                     window_last
);

	logic [5:0]       motif_length_q;
	logic [REC_W-1:0] score_recip_q;
	logic [LEN_W-1:0] bases_seen_q;

	logic             adv;
	logic             in_acc;
	logic             base_acc;
	logic             load_acc;
	logic [LEN_W-1:0] len_eff;
	logic [COL_W-1:0] len_m1;
	base_dec_t        dec;
	cell_ctl_t        ctl;
	wt_wr_t           wr_cell [MAX_MOTIF_LEN];
	logic             take    [MAX_MOTIF_LEN];
	logic signed [SUM_W-1:0] chain_in  [MAX_MOTIF_LEN];
	logic signed [SUM_W-1:0] chain_out [MAX_MOTIF_LEN];
	logic signed [SUM_W-1:0] done;

	logic [LEN_W-1:0] bs_start;
	logic [LEN_W-1:0] bs_count;
	logic [LEN_W-1:0] bs_next;
	logic             emit;
	logic             emit_short;

	logic                    v_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic                    status_s1;
	logic                    last_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     status_s2;
	logic                     last_s2;

	logic signed [PROD_W-1:0] rounded;
	logic signed [QUO_W-1:0]  quo;
	logic signed [NORM_W-1:0] sat;

	logic                     out_valid_q;
	logic signed [NORM_W-1:0] norm_score_q;
	logic                     status_q;
	logic                     window_last_q;

	// Handshake: the whole pipeline moves unless a result waits
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;
	assign base_acc = in_acc && (kind == KIND_BASE);
	assign load_acc = in_acc && (kind == KIND_LOAD);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_length_q <= MOTIF_LENGTH_RST;
			score_recip_q  <= SCORE_RECIP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MOTIF_LENGTH: motif_length_q <= cfg_data[5:0];
				REG_SCORE_RECIP:  score_recip_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Clamp the motif length to the chain
	always_comb begin
		len_eff = LEN_W'(motif_length_q);
		if (len_eff == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_eff > LEN_W'(MAX_MOTIF_LEN)) begin
			len_eff = LEN_W'(MAX_MOTIF_LEN);
		end
	end

	assign len_m1 = COL_W'(len_eff - LEN_W'(1));
	assign dec    = decode_base(base_char);

	// Broadcast the base step
	always_comb begin
		ctl.shift = base_acc;
		ctl.hit   = dec.hit;
		ctl.row   = dec.row;
	end

	// Row of cells; cell zero always restarts a window at zero
	for (genvar j = 0; j < MAX_MOTIF_LEN; j++) begin : g_cell
		assign wr_cell[j].en    = load_acc && (LEN_W'(weight_column) == LEN_W'(j));
		assign wr_cell[j].row   = weight_row;
		assign wr_cell[j].value = weight_value;
		assign take[j]          = LEN_W'(j) < len_eff;
		if (j == 0) begin : g_head
			assign chain_in[j] = '0;
		end else begin : g_link
			assign chain_in[j] = chain_out[j-1];
		end

		spms_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr_cell[j]),
			.ctl     (ctl),
			.take    (take[j]),
			.sum_in  (chain_in[j]),
			.sum_out (chain_out[j])
		);
	end

	// Tap the completed window at the last column in use
	assign done = chain_out[len_m1];

	// Count bases of the current sequence and decide the result
	always_comb begin
		bs_start   = seq_first ? '0 : bases_seen_q;
		bs_count   = (bs_start < len_eff) ? bs_start + LEN_W'(1) : bs_start;
		emit       = bs_count >= len_eff;
		emit_short = !emit && seq_final;
		bs_next    = seq_final ? '0 : bs_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bases_seen_q <= '0;
		end else if (base_acc) begin
			bases_seen_q <= bs_next;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= base_acc && (emit || emit_short);
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// Stage 1: window sum, zero for a short sequence
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1    <= emit ? done : '0;
			status_s1 <= emit ? STATUS_OK : STATUS_SHORT;
			last_s1   <= seq_final;
		end
	end

	// Stage 2: scale by the reciprocal
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2   <= PROD_W'(sum_s1) * PROD_W'($signed({1'b0, score_recip_q}));
			status_s2 <= status_s1;
			last_s2   <= last_s1;
		end
	end

	// Round half up, floor, saturate
	always_comb begin
		rounded = prod_s2 + RND_BIAS;
		quo     = QUO_W'(rounded >>> RND_SHIFT);
		if (quo > NORM_MAX) begin
			sat = NORM_W'(NORM_MAX);
		end else if (quo < NORM_MIN) begin
			sat = NORM_W'(NORM_MIN);
		end else begin
			sat = NORM_W'(quo);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			norm_score_q  <= sat;
			status_q      <= status_s2;
			window_last_q <= last_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign norm_score  = norm_score_q;
	assign status      = status_q;
	assign window_last = window_last_q;

	// A short-sequence result is the last of its sequence and scores zero
	`CHK_NOW(a_short_result, clk, arst_n, out_valid && (status == STATUS_SHORT), (norm_score == '0) && window_last)
	// A final base restarts the count
	`CHK_NEXT(a_final_clears, clk, arst_n, base_acc && seq_final, bases_seen_q == '0)
	// A weight load gives no result
	`CHK_NEXT(a_load_silent, clk, arst_n, load_acc, !v_s1)
	// A held stage keeps its sum
	`CHK_NEXT(a_s1_hold, clk, arst_n, v_s1 && !adv, v_s1 && $stable(sum_s1))

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench of the sliding motif score core: directed and random words.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import spms_pkg::*;

	localparam int NO_ROW = -1;
	localparam int QUIET_LIMIT = 4000;
	localparam int GAP_CAP = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RAND_PHASES = 8;
	localparam int WORDS_PER_PHASE = 175;
	localparam logic [7:0] CHAR_N_UP = 8'h4E;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_ALL_ONES = 8'hFF;

	typedef struct {
		logic signed [NORM_W-1:0] score;
		logic                     stat;
		logic                     last;
	} score_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [REC_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic [1:0] weight_row;
	logic [4:0] weight_column;
	logic signed [WGT_W-1:0] weight_value;
	logic [7:0] base_char;
	logic seq_first;
	logic seq_final;
	logic out_valid;
	logic out_stall;
	logic signed [NORM_W-1:0] norm_score;
	logic status;
	logic window_last;

	// Scoreboard state
	score_t pending_scores[$];
	score_t want;
	int fail_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// Shadow of the core: registers, weight matrix, window chain, base count
	logic [5:0] motif_len_reg;
	logic [REC_W-1:0] recip_reg;
	logic signed [WGT_W-1:0] weights [4][MAX_MOTIF_LEN];
	logic signed [SUM_W-1:0] chain_sums [MAX_MOTIF_LEN];
	int bases_in_seq;

	sliding_pwm_motif_score_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.weight_row(weight_row),
		.weight_column(weight_column),
		.weight_value(weight_value),
		.base_char(base_char),
		.seq_first(seq_first),
		.seq_final(seq_final),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.norm_score(norm_score),
		.status(status),
		.window_last(window_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at the rate of the current phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Compare each accepted result word with the oldest expected score
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				$error("unexpected result: norm_score %0d status %0b window_last %0b",
					norm_score, status, window_last);
				fail_count++;
			end else begin
				want = pending_scores.pop_front();
				if (norm_score !== want.score) begin
					$error("norm_score: expected %0d, got %0d", want.score, norm_score);
					fail_count++;
				end
				if (status !== want.stat) begin
					$error("status: expected %0b, got %0b", want.stat, status);
					fail_count++;
				end
				if (window_last !== want.last) begin
					$error("window_last: expected %0b, got %0b", want.last, window_last);
					fail_count++;
				end
			end
		end
	end

	function automatic int char_row(input logic [7:0] ch);
		case (ch)
			CHAR_A_UP, CHAR_A_LO: return int'(ROW_A);
			CHAR_C_UP, CHAR_C_LO: return int'(ROW_C);
			CHAR_G_UP, CHAR_G_LO: return int'(ROW_G);
			CHAR_T_UP, CHAR_T_LO: return int'(ROW_T);
			default: return NO_ROW;
		endcase
	endfunction

	function automatic int table_weight(input int r, input int c);
		if (r == NO_ROW)
			return 0;
		return int'(weights[r][c]);
	endfunction

	// Clamp the length register to the chain
	function automatic int effective_len();
		int n;
		n = int'(motif_len_reg);
		if (n == 0)
			n = 1;
		if (n > MAX_MOTIF_LEN)
			n = MAX_MOTIF_LEN;
		return n;
	endfunction

	// Scale a Q8.8 window sum by the reciprocal, round half up, saturate
	function automatic logic signed [NORM_W-1:0] scale_sum(input longint wsum);
		longint q;
		q = (wsum * longint'({32'b0, recip_reg}) + 256) >>> RND_SHIFT;
		if (q > NORM_MAX)
			q = NORM_MAX;
		if (q < NORM_MIN)
			q = NORM_MIN;
		return NORM_W'(q);
	endfunction

	// Advance the shadow by one accepted word and queue the score it yields
	task automatic predict_score(input logic k, input logic [1:0] row, input logic [4:0] col,
			input logic signed [WGT_W-1:0] wval, input logic [7:0] ch,
			input logic is_first, input logic is_final);
		int len;
		int r;
		longint wsum;
		score_t res;
		if (k == KIND_LOAD) begin
			if (int'(col) < MAX_MOTIF_LEN)
				weights[row][col] = wval;
			return;
		end
		len = effective_len();
		if (is_first)
			bases_in_seq = 0;
		r = char_row(ch);
		wsum = longint'(chain_sums[len-1]) + table_weight(r, len - 1);
		for (int j = len - 1; j >= 1; j--)
			chain_sums[j] = SUM_W'(int'(chain_sums[j-1]) + table_weight(r, j - 1));
		chain_sums[0] = '0;
		if (bases_in_seq < len)
			bases_in_seq++;
		if (bases_in_seq >= len) begin
			res.score = scale_sum(wsum);
			res.stat = STATUS_OK;
			res.last = is_final;
			pending_scores.push_back(res);
			if (is_final)
				bases_in_seq = 0;
		end else if (is_final) begin
			bases_in_seq = 0;
			res.score = '0;
			res.stat = STATUS_SHORT;
			res.last = 1'b1;
			pending_scores.push_back(res);
		end
	endtask

	// Drive one word, hold it until taken, then advance the shadow
	task automatic send_word(input logic k, input logic [1:0] row, input logic [4:0] col,
			input logic [WGT_W-1:0] wval, input logic [7:0] ch,
			input logic is_first, input logic is_final);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		weight_row <= row;
		weight_column <= col;
		weight_value <= wval;
		base_char <= ch;
		seq_first <= is_first;
		seq_final <= is_final;
		do @(posedge clk); while (in_stall);
		predict_score(k, row, col, wval, ch, is_first, is_final);
	endtask

	task automatic send_base(input logic [7:0] ch, input logic is_first, input logic is_final);
		send_word(KIND_BASE, 2'($urandom), 5'($urandom), 16'($urandom), ch, is_first, is_final);
	endtask

	task automatic send_load(input logic [1:0] row, input logic [4:0] col,
			input logic [WGT_W-1:0] wval);
		send_word(KIND_LOAD, row, col, wval, 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// Drop valid and wait until every queued score has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
	endtask

	// Write one register once the core is empty and settled
	task automatic write_reg(input logic idx, input logic [REC_W-1:0] val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MOTIF_LENGTH)
			motif_len_reg = val[5:0];
		else
			recip_reg = val;
	endtask

	function automatic logic [7:0] random_char();
		if ($urandom_range(99) < 12)
			return 8'($urandom);
		case ($urandom_range(7))
			0: return CHAR_A_UP;
			1: return CHAR_A_LO;
			2: return CHAR_C_UP;
			3: return CHAR_C_LO;
			4: return CHAR_G_UP;
			5: return CHAR_G_LO;
			6: return CHAR_T_UP;
			default: return CHAR_T_LO;
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] random_weight();
		if ($urandom_range(1) == 0)
			return WGT_W'(int'($urandom_range(2047)) - 1024);
		return WGT_W'($urandom);
	endfunction

	// Fill the whole matrix: row A at the top limit, row C at the bottom limit
	task automatic load_weight_table();
		for (int c = 0; c < MAX_MOTIF_LEN; c++) begin
			send_load(ROW_A, 5'(c), 16'h7FFF);
			send_load(ROW_C, 5'(c), 16'h8000);
			send_load(ROW_G, 5'(c), 16'h0100);
			send_load(ROW_T, 5'(c), random_weight());
		end
	endtask

	// One-base windows: every letter in both cases and a few misses
	task automatic test_char_decode();
		logic [7:0] chars [11];
		chars = '{CHAR_A_UP, CHAR_A_LO, CHAR_C_UP, CHAR_C_LO, CHAR_G_UP, CHAR_G_LO,
			CHAR_T_UP, CHAR_T_LO, CHAR_N_UP, CHAR_NUL, CHAR_ALL_ONES};
		foreach (chars[i])
			send_base(chars[i], 1'b1, 1'b1);
	endtask

	// Sequences that end before the motif fills, one of them never marked first
	task automatic test_short_sequence();
		write_reg(REG_MOTIF_LENGTH, 3);
		send_base(CHAR_A_UP, 1'b1, 1'b0);
		send_base(CHAR_C_UP, 1'b0, 1'b1);
		send_base(CHAR_G_LO, 1'b0, 1'b1);
	endtask

	// Length zero, reciprocal at both ends, saturation in both directions
	task automatic test_register_extremes();
		write_reg(REG_MOTIF_LENGTH, 0);
		send_base(CHAR_T_UP, 1'b1, 1'b1);
		write_reg(REG_SCORE_RECIP, 32'hFFFF_FFFF);
		send_base(CHAR_A_UP, 1'b1, 1'b1);
		send_base(CHAR_C_LO, 1'b1, 1'b1);
		write_reg(REG_SCORE_RECIP, 0);
		send_base(CHAR_G_UP, 1'b1, 1'b1);
		write_reg(REG_SCORE_RECIP, SCORE_RECIP_RST);
	endtask

	// Pause inside a sequence, reload a weight, then change the length mid-sequence
	task automatic test_midsequence_changes();
		write_reg(REG_MOTIF_LENGTH, 2);
		send_base(CHAR_A_UP, 1'b1, 1'b0);
		send_base(CHAR_C_UP, 1'b0, 1'b0);
		wait_drained();
		send_load(ROW_G, 5'd1, random_weight());
		send_base(CHAR_G_UP, 1'b0, 1'b0);
		write_reg(REG_MOTIF_LENGTH, 3);
		send_base(CHAR_T_UP, 1'b0, 1'b0);
		send_base(CHAR_A_LO, 1'b0, 1'b1);
	endtask

	// Mostly well-formed sequences with stray loads, plus noise words
	task automatic test_random_streams();
		int sent;
		int len;
		int n;
		logic [REC_W-1:0] recip;
		logic [5:0] mlen;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin mlen = 6'd1; recip = SCORE_RECIP_RST; end
				1: begin mlen = 6'($urandom_range(2, 8)); recip = $urandom; end
				2: begin mlen = 6'd32; recip = $urandom_range(4096); end
				3: begin mlen = 6'd0; recip = 32'hFFFF_FFFF; end
				4: begin mlen = 6'd63; recip = SCORE_RECIP_RST; end
				5: begin mlen = 6'($urandom_range(9, 31)); recip = 0; end
				6: begin mlen = 6'd40; recip = $urandom_range(65536); end
				default: begin mlen = 6'd3; recip = $urandom; end
			endcase
			write_reg(REG_MOTIF_LENGTH, REC_W'(mlen));
			write_reg(REG_SCORE_RECIP, recip);
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 88; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 88; end
				default: begin send_idle_pct = 31; stall_pct = 31; end
			endcase
			len = effective_len();
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				if ($urandom_range(9) == 0) begin
					// noise word: any kind, any byte, any marks
					send_word(1'($urandom), 2'($urandom), 5'($urandom), random_weight(),
						8'($urandom), 1'($urandom), 1'($urandom));
					sent++;
				end else begin
					if ($urandom_range(4) == 0)
						n = $urandom_range(1, len);
					else
						n = $urandom_range(len, len + 12);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(24) == 0) begin
							send_load(2'($urandom), 5'($urandom), random_weight());
							sent++;
						end
						send_base(random_char(), i == 0, i == n - 1);
						sent++;
					end
				end
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MOTIF_LENGTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_BASE;
		weight_row <= ROW_A;
		weight_column <= '0;
		weight_value <= '0;
		base_char <= '0;
		seq_first <= 1'b0;
		seq_final <= 1'b0;
		out_stall <= 1'b0;
		motif_len_reg = MOTIF_LENGTH_RST;
		recip_reg = SCORE_RECIP_RST;
		bases_in_seq = 0;
		foreach (chain_sums[j])
			chain_sums[j] = '0;
		foreach (weights[r, c])
			weights[r][c] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_weight_table();
		test_char_decode();
		test_short_sequence();
		test_register_extremes();
		test_midsequence_changes();
		test_random_streams();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_scores.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
